FILE: src/circular_extremum_picker_macros.svh
// assertion macros for the extremum picker
`ifndef CIRCULAR_EXTREMUM_PICKER_MACROS_SVH
`define CIRCULAR_EXTREMUM_PICKER_MACROS_SVH

`ifndef SYNTHESIS
`define CEP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define CEP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define CEP_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define CEP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: src/cep_pkg.sv
`default_nettype none
package cep_pkg;
	localparam int SAMPLE_DEPTH = 1024;
	localparam int MAX_KEPT = 64;
	localparam int VALUE_BITS = 16;

	localparam int IDX_W = $clog2(SAMPLE_DEPTH);
	localparam int CNT_W = IDX_W + 1;
	localparam int KEPT_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
	localparam int KCNT_W = $clog2(MAX_KEPT + 1);
	localparam int POS_W = 10;
	localparam int THR_W = 16;
	localparam int SEP_W = 11;
	localparam int CAP_W = 7;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int DIST_W = ((CNT_W > SEP_W) ? CNT_W : SEP_W) + 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD = 2'd0,
		REG_MIN_SEP   = 2'd1,
		REG_TROUGH    = 2'd2,
		REG_MAX_REP   = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] sample_value;
		logic                         last_sample;
	} sample_item_t;

	typedef struct packed {
		logic [POS_W-1:0]             position;
		logic signed [VALUE_BITS-1:0] extremum_value;
		logic                         none_found;
		logic                         last_result;
	} result_item_t;

	typedef struct packed {
		logic signed [THR_W-1:0] threshold;
		logic [SEP_W-1:0]        min_separation;
		logic                    trough_mode;
		logic [CAP_W-1:0]        max_reported;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEL,
		ST_SCAN,
		ST_DRAIN,
		ST_MARK,
		ST_CHK_RD,
		ST_CHK_EV,
		ST_ACCEPT,
		ST_OUT_RD,
		ST_OUT_EV,
		ST_NONE
	} state_t;
endpackage
`default_nettype wire

FILE: src/cep_ram.sv
`default_nettype none
module cep_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: src/cep_cfg.sv
`default_nettype none
module cep_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [cep_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [cep_pkg::CFG_DATA_W-1:0] cfg_data,
	output cep_pkg::cfg_t                      cfg
);
	import cep_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold      <= THR_W'(1792);
			cfg_q.min_separation <= SEP_W'(32);
			cfg_q.trough_mode    <= 1'b0;
			cfg_q.max_reported   <= CAP_W'(10);
		end else if (cfg_valid) begin
			case (reg_index_t'(cfg_index))
				REG_THRESHOLD: cfg_q.threshold <= cfg_data[THR_W-1:0];
				REG_MIN_SEP:   cfg_q.min_separation <= cfg_data[SEP_W-1:0];
				REG_TROUGH:    cfg_q.trough_mode <= cfg_data[0];
				REG_MAX_REP:   cfg_q.max_reported <= cfg_data[CAP_W-1:0];
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: src/circular_extremum_picker.sv
// Samples of one closed contour load at one per cycle while busy is low; the
// sample marked last starts selection and busy stays high until the last result
// has been shown. Each pick walks the sample memory over entries 1 to n-2, then
// checks the pick against the accepted list one accepted entry at a time, with a
// read state and a compare state per entry; a run makes one pick per candidate
// visited. Results then leave in turn, each read from the kept list and then
// shown on the result ports for one cycle with result_valid high; the receiver
// cannot stall them and must take each when it appears.
`default_nettype none
`include "circular_extremum_picker_macros.svh"
module circular_extremum_picker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire cep_pkg::sample_item_t          sample,
	output logic                               result_valid,
	output cep_pkg::result_item_t              result,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [cep_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [cep_pkg::CFG_DATA_W-1:0] cfg_data
);
	import cep_pkg::*;

	localparam int SW_W = VALUE_BITS + 1;
	localparam int LW_W = IDX_W + VALUE_BITS;

	cfg_t cfg;
	state_t state_q, state_d;

	logic [CNT_W-1:0]  count_q, n_q;
	logic [KCNT_W-1:0] acc_cnt_q, k_q;
	logic [IDX_W-1:0]  scan_q, idx_s1, best_idx_q;
	logic              rd_vld_s1, found_q;
	logic signed [VALUE_BITS-1:0] best_val_q;

	logic              s_we;
	logic [IDX_W-1:0]  s_waddr, s_raddr;
	logic [SW_W-1:0]   s_wdata, s_rdata;
	logic              l_we;
	logic [KEPT_W-1:0] l_waddr, l_raddr;
	logic [LW_W-1:0]   l_wdata, l_rdata;

	logic [KCNT_W-1:0] cap;
	logic              rd_taken, cand, better;
	logic signed [VALUE_BITS-1:0] rd_val, l_val;
	logic [IDX_W-1:0]  l_idx, diff;
	logic              near;

	cep_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cep_ram #(.DEPTH(SAMPLE_DEPTH), .WIDTH(SW_W)) u_samples (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	cep_ram #(.DEPTH(MAX_KEPT), .WIDTH(LW_W)) u_kept (
		.clk   (clk),
		.we    (l_we),
		.waddr (l_waddr),
		.wdata (l_wdata),
		.raddr (l_raddr),
		.rdata (l_rdata)
	);

	always_comb begin
		if (cfg.max_reported == '0) begin
			cap = KCNT_W'(1);
		end else if (32'(cfg.max_reported) > MAX_KEPT) begin
			cap = KCNT_W'(MAX_KEPT);
		end else begin
			cap = KCNT_W'(cfg.max_reported);
		end
	end

	// candidate test on the registered sample read
	assign rd_taken = s_rdata[SW_W-1];
	assign rd_val   = s_rdata[VALUE_BITS-1:0];
	assign cand     = !rd_taken && (cfg.trough_mode ? (rd_val < cfg.threshold)
	                                                : (rd_val > cfg.threshold));
	assign better   = !found_q || (cfg.trough_mode ? (rd_val < best_val_q)
	                                               : (rd_val > best_val_q));

	// circular distance check against one accepted entry
	assign l_idx = l_rdata[LW_W-1:VALUE_BITS];
	assign l_val = l_rdata[VALUE_BITS-1:0];
	assign diff  = (l_idx > best_idx_q) ? (l_idx - best_idx_q) : (best_idx_q - l_idx);
	assign near  = ($signed(DIST_W'(diff)) < $signed(DIST_W'(cfg.min_separation))) ||
	               ($signed(DIST_W'(diff)) >
	                $signed(DIST_W'(n_q)) - $signed(DIST_W'(cfg.min_separation)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			acc_cnt_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= (state_q == ST_SCAN);
			case (state_q)
				ST_IDLE: begin
					if (start && (32'(count_q) < SAMPLE_DEPTH)) begin
						count_q <= count_q + 1'b1;
					end
				end
				ST_ACCEPT: begin
					acc_cnt_q <= acc_cnt_q + 1'b1;
				end
				ST_OUT_EV: begin
					if (k_q + 1'b1 == acc_cnt_q) begin
						count_q   <= '0;
						acc_cnt_q <= '0;
					end
				end
				ST_NONE: begin
					count_q   <= '0;
					acc_cnt_q <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_q;
		if (rd_vld_s1 && cand && better) begin
			found_q    <= 1'b1;
			best_idx_q <= idx_s1;
			best_val_q <= rd_val;
		end
		case (state_q)
			ST_IDLE: begin
				if (start && sample.last_sample) begin
					n_q <= (32'(count_q) < SAMPLE_DEPTH) ? count_q + 1'b1 : count_q;
				end
			end
			ST_SEL: begin
				scan_q  <= IDX_W'(1);
				found_q <= 1'b0;
				k_q     <= '0;
			end
			ST_SCAN:   scan_q <= scan_q + 1'b1;
			ST_MARK:   k_q <= '0;
			ST_CHK_EV: k_q <= k_q + 1'b1;
			ST_OUT_EV: k_q <= k_q + 1'b1;
			default: ;
		endcase
	end

	always_comb begin
		state_d      = state_q;
		s_we         = 1'b0;
		s_waddr      = count_q[IDX_W-1:0];
		s_wdata      = {1'b0, sample.sample_value};
		s_raddr      = scan_q;
		l_we         = 1'b0;
		l_waddr      = acc_cnt_q[KEPT_W-1:0];
		l_wdata      = {best_idx_q, best_val_q};
		l_raddr      = k_q[KEPT_W-1:0];
		result_valid = 1'b0;
		result       = '0;
		case (state_q)
			ST_IDLE: begin
				s_we = start && (32'(count_q) < SAMPLE_DEPTH);
				if (start && sample.last_sample) begin
					state_d = ST_SEL;
				end
			end
			ST_SEL: begin
				if (acc_cnt_q == cap || n_q < CNT_W'(3)) begin
					state_d = (acc_cnt_q == '0) ? ST_NONE : ST_OUT_RD;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_q == IDX_W'(n_q - CNT_W'(2))) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_MARK;
			ST_MARK: begin
				if (!found_q) begin
					state_d = (acc_cnt_q == '0) ? ST_NONE : ST_OUT_RD;
				end else begin
					s_we    = 1'b1;
					s_waddr = best_idx_q;
					s_wdata = {1'b1, best_val_q};
					state_d = (acc_cnt_q == '0) ? ST_ACCEPT : ST_CHK_RD;
				end
			end
			ST_CHK_RD: state_d = ST_CHK_EV;
			ST_CHK_EV: begin
				if (near) begin
					state_d = ST_SEL;
				end else if (k_q + 1'b1 == acc_cnt_q) begin
					state_d = ST_ACCEPT;
				end else begin
					state_d = ST_CHK_RD;
				end
			end
			ST_ACCEPT: begin
				l_we    = 1'b1;
				state_d = ST_SEL;
			end
			ST_OUT_RD: state_d = ST_OUT_EV;
			ST_OUT_EV: begin
				result_valid          = 1'b1;
				result.position       = POS_W'(l_idx);
				result.extremum_value = l_val;
				result.last_result    = (k_q + 1'b1 == acc_cnt_q);
				state_d = result.last_result ? ST_IDLE : ST_OUT_RD;
			end
			ST_NONE: begin
				result_valid       = 1'b1;
				result.none_found  = 1'b1;
				result.last_result = 1'b1;
				state_d            = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	`CEP_ASSERT_SAME(a_result_busy, clk, arst_n, result_valid, busy)
	`CEP_ASSERT_SAME(a_none_is_last, clk, arst_n, result_valid && result.none_found, result.last_result)
	`CEP_ASSERT_SAME(a_idle_clean, clk, arst_n, !busy, acc_cnt_q == '0)
	`CEP_ASSERT_NEXT(a_plain_sample, clk, arst_n, start && !busy && !sample.last_sample, !busy)
	`CEP_ASSERT_SAME(a_kept_cap, clk, arst_n, busy, acc_cnt_q <= cap)
endmodule
`default_nettype wire
